### sv/ttf_pkg.sv
// Shared constants, controller states and command/status types for the tangent frame core.
package ttf_pkg;

  // Default field widths.
  localparam int COORD_WIDTH_DEF = 24;
  localparam int UNIT_WIDTH_DEF  = 16;

  // The largest tangent component magnitude is normalized into [2^(NORM_BITS-1), 2^NORM_BITS).
  localparam int NORM_BITS = 30;

  // Widest coordinate delta kept before the tangent products.
  localparam int DELTA_MAX_BITS = 31;

  // Corner indexes within a face.
  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_LAST  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DELTA,
    ST_TPROD,
    ST_TDIFF,
    ST_ABS,
    ST_NORM,
    ST_SQM,
    ST_SQA,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_WR,
    ST_CROSS1,
    ST_BIN,
    ST_CROSS2,
    ST_TAN,
    ST_EMIT
  } ttf_state_e;

  typedef struct packed {
    logic       store;
    logic       take_third;
    logic       delta;
    logic       tprod;
    logic       tdiff;
    logic       abs_ld;
    logic       norm_right;
    logic       norm_left;
    logic       sq_clr;
    logic       sq_mul;
    logic       sq_acc;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_wr;
    logic       tn_zero;
    logic       cross_ld;
    logic       cross_sel;
    logic       b_ld;
    logic       tg_ld;
    logic       out_ld;
    logic       idx;
    logic [1:0] comp;
    logic [1:0] corner;
  } ttf_cmd_t;

  typedef struct packed {
    logic mag_zero;
    logic norm_right;
    logic norm_left;
    logic sqrt_last;
    logic div_last;
    logic out_free;
  } ttf_sts_t;

endpackage

### sv/ttf_if.sv
// Valid/ready channel interfaces for vertex input beats and frame output beats.
interface ttf_in_if #(
  parameter int COORD_WIDTH = ttf_pkg::COORD_WIDTH_DEF,
  parameter int UNIT_WIDTH  = ttf_pkg::UNIT_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic signed [COORD_WIDTH-1:0] tex_u;
  logic signed [COORD_WIDTH-1:0] tex_v;
  logic signed [UNIT_WIDTH-1:0]  norm_x;
  logic signed [UNIT_WIDTH-1:0]  norm_y;
  logic signed [UNIT_WIDTH-1:0]  norm_z;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
                output ready);
endinterface

interface ttf_out_if #(
  parameter int UNIT_WIDTH = ttf_pkg::UNIT_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   corner;
  logic signed [UNIT_WIDTH-1:0] tan_x;
  logic signed [UNIT_WIDTH-1:0] tan_y;
  logic signed [UNIT_WIDTH-1:0] tan_z;
  logic signed [UNIT_WIDTH-1:0] bin_x;
  logic signed [UNIT_WIDTH-1:0] bin_y;
  logic signed [UNIT_WIDTH-1:0] bin_z;
  logic                         face_done;

  modport source (output valid, corner, tan_x, tan_y, tan_z, bin_x, bin_y, bin_z, face_done,
                  input ready);
  modport sink (input valid, corner, tan_x, tan_y, tan_z, bin_x, bin_y, bin_z, face_done,
                output ready);
endinterface

### sv/ttf_ctrl.sv
// Sequencer for the tangent frame core: steps the datapath through one face.
module ttf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ttf_pkg::ttf_sts_t sts_i,
  output ttf_pkg::ttf_cmd_t cmd_o
);
  import ttf_pkg::*;

  ttf_state_e state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] k_q, k_d;
  logic [1:0] c_q, c_d;

  // State and loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      c_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      c_q     <= c_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    c_d         = c_q;
    cmd_o       = '0;
    cmd_o.idx   = cnt_q[0];
    cmd_o.comp  = k_q;
    cmd_o.corner = c_q;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q < CORNER_LAST) begin
            cmd_o.store = 1'b1;
            cnt_d       = cnt_q + 2'd1;
          end else begin
            cmd_o.take_third = 1'b1;
            cnt_d            = '0;
            state_d          = ST_DELTA;
          end
        end
      end
      ST_DELTA: begin
        cmd_o.delta = 1'b1;
        k_d         = '0;
        state_d     = ST_TPROD;
      end
      ST_TPROD: begin
        cmd_o.tprod = 1'b1;
        state_d     = ST_TDIFF;
      end
      ST_TDIFF: begin
        cmd_o.tdiff = 1'b1;
        if (k_q == CORNER_LAST) begin
          k_d     = '0;
          state_d = ST_ABS;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = ST_TPROD;
        end
      end
      ST_ABS: begin
        cmd_o.abs_ld = 1'b1;
        state_d      = ST_NORM;
      end
      ST_NORM: begin
        if (sts_i.mag_zero) begin
          cmd_o.tn_zero = 1'b1;
          c_d           = CORNER_FIRST;
          state_d       = ST_CROSS1;
        end else if (sts_i.norm_right) begin
          cmd_o.norm_right = 1'b1;
        end else if (sts_i.norm_left) begin
          cmd_o.norm_left = 1'b1;
        end else begin
          cmd_o.sq_clr = 1'b1;
          k_d          = '0;
          state_d      = ST_SQM;
        end
      end
      ST_SQM: begin
        cmd_o.sq_mul = 1'b1;
        state_d      = ST_SQA;
      end
      ST_SQA: begin
        cmd_o.sq_acc = 1'b1;
        if (k_q == CORNER_LAST) begin
          k_d     = '0;
          state_d = ST_SQRT_INIT;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = ST_SQM;
        end
      end
      ST_SQRT_INIT: begin
        cmd_o.sqrt_init = 1'b1;
        state_d         = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_last) state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_DIV_WR;
      end
      ST_DIV_WR: begin
        cmd_o.div_wr = 1'b1;
        if (k_q == CORNER_LAST) begin
          k_d     = '0;
          c_d     = CORNER_FIRST;
          state_d = ST_CROSS1;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = ST_DIV_INIT;
        end
      end
      ST_CROSS1: begin
        cmd_o.cross_ld = 1'b1;
        state_d        = ST_BIN;
      end
      ST_BIN: begin
        cmd_o.b_ld = 1'b1;
        state_d    = ST_CROSS2;
      end
      ST_CROSS2: begin
        cmd_o.cross_ld  = 1'b1;
        cmd_o.cross_sel = 1'b1;
        state_d         = ST_TAN;
      end
      ST_TAN: begin
        cmd_o.tg_ld = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register can take the beat
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          if (c_q == CORNER_LAST) begin
            c_d     = CORNER_FIRST;
            state_d = ST_IDLE;
          end else begin
            c_d     = c_q + 2'd1;
            state_d = ST_CROSS1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### sv/ttf_dp.sv
// Datapath: corner store, face tangent, normalization, square root, division and cross products.
module ttf_dp #(
  parameter int COORD_WIDTH = ttf_pkg::COORD_WIDTH_DEF,
  parameter int UNIT_WIDTH  = ttf_pkg::UNIT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ttf_pkg::ttf_cmd_t             cmd_i,
  output ttf_pkg::ttf_sts_t             sts_o,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic signed [COORD_WIDTH-1:0] tex_v_i,
  input  logic signed [UNIT_WIDTH-1:0]  norm_x_i,
  input  logic signed [UNIT_WIDTH-1:0]  norm_y_i,
  input  logic signed [UNIT_WIDTH-1:0]  norm_z_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [1:0]                    corner_o,
  output logic signed [UNIT_WIDTH-1:0]  tan_x_o,
  output logic signed [UNIT_WIDTH-1:0]  tan_y_o,
  output logic signed [UNIT_WIDTH-1:0]  tan_z_o,
  output logic signed [UNIT_WIDTH-1:0]  bin_x_o,
  output logic signed [UNIT_WIDTH-1:0]  bin_y_o,
  output logic signed [UNIT_WIDTH-1:0]  bin_z_o,
  output logic                          face_done_o
);
  import ttf_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int UW   = UNIT_WIDTH;
  localparam int FRAC = UW - 2;
  localparam int ONE  = 2 ** FRAC;
  localparam int DSH  = (CW + 1 > DELTA_MAX_BITS) ? CW + 1 - DELTA_MAX_BITS : 0;
  localparam int DW   = CW + 1 - DSH;
  localparam int MW   = 2 * DW;
  localparam int TW   = MW + 1;
  localparam int NB   = NORM_BITS;
  localparam int SW   = 2 * NB + 2;
  localparam int RTW  = NB + 1;
  localparam int RW   = NB + 2;
  localparam int QW   = FRAC + 1;
  localparam int ND   = NB + FRAC + 1;
  localparam int CNW  = $clog2(QW);
  localparam int PW   = 2 * UW;
  localparam int XW   = 2 * UW + 2;

  // Difference of two coordinates, floor-shifted to the delta width
  function automatic logic signed [DW-1:0] delta_f(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    logic signed [CW:0] diff;
    logic signed [CW:0] sh;
    diff = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    sh   = diff >>> DSH;
    return sh[DW-1:0];
  endfunction

  // Difference of two Q3.28 products, rounded half-up to Q1.14 and saturated
  function automatic logic signed [UW-1:0] rsat_f(input logic signed [PW-1:0] p,
                                                  input logic signed [PW-1:0] q);
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    x = $signed({{2{p[PW-1]}}, p}) - $signed({{2{q[PW-1]}}, q}) + XW'(ONE / 2);
    y = x >>> FRAC;
    if (y > $signed(XW'(ONE))) y = XW'(ONE);
    if (y < -$signed(XW'(ONE))) y = -$signed(XW'(ONE));
    return y[UW-1:0];
  endfunction

  // Corner store and third-corner capture
  logic signed [CW-1:0] sp_x_q [2];
  logic signed [CW-1:0] sp_y_q [2];
  logic signed [CW-1:0] sp_z_q [2];
  logic signed [CW-1:0] sv_q   [2];
  logic signed [UW-1:0] sn_x_q [2];
  logic signed [UW-1:0] sn_y_q [2];
  logic signed [UW-1:0] sn_z_q [2];
  logic signed [CW-1:0] cp_x_q, cp_y_q, cp_z_q, cv_q;
  logic signed [UW-1:0] cn_x_q, cn_y_q, cn_z_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      sp_x_q[cmd_i.idx] <= pos_x_i;
      sp_y_q[cmd_i.idx] <= pos_y_i;
      sp_z_q[cmd_i.idx] <= pos_z_i;
      sv_q[cmd_i.idx]   <= tex_v_i;
      sn_x_q[cmd_i.idx] <= norm_x_i;
      sn_y_q[cmd_i.idx] <= norm_y_i;
      sn_z_q[cmd_i.idx] <= norm_z_i;
    end
    if (cmd_i.take_third) begin
      cp_x_q <= pos_x_i;
      cp_y_q <= pos_y_i;
      cp_z_q <= pos_z_i;
      cv_q   <= tex_v_i;
      cn_x_q <= norm_x_i;
      cn_y_q <= norm_y_i;
      cn_z_q <= norm_z_i;
    end
  end

  // Edge deltas and face tangent, one component per product/difference pair
  logic signed [DW-1:0] d1_q [3];
  logic signed [DW-1:0] d2_q [3];
  logic signed [DW-1:0] dv1_q, dv2_q;
  logic signed [MW-1:0] p1_q, p2_q;
  logic signed [TW-1:0] t_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.delta) begin
      d1_q[0] <= delta_f(sp_x_q[1], sp_x_q[0]);
      d1_q[1] <= delta_f(sp_y_q[1], sp_y_q[0]);
      d1_q[2] <= delta_f(sp_z_q[1], sp_z_q[0]);
      d2_q[0] <= delta_f(cp_x_q, sp_x_q[0]);
      d2_q[1] <= delta_f(cp_y_q, sp_y_q[0]);
      d2_q[2] <= delta_f(cp_z_q, sp_z_q[0]);
      dv1_q   <= delta_f(sv_q[1], sv_q[0]);
      dv2_q   <= delta_f(cv_q, sv_q[0]);
    end
    if (cmd_i.tprod) begin
      p1_q <= d1_q[cmd_i.comp] * dv2_q;
      p2_q <= d2_q[cmd_i.comp] * dv1_q;
    end
    if (cmd_i.tdiff) begin
      t_q[cmd_i.comp] <= $signed({p1_q[MW-1], p1_q}) - $signed({p2_q[MW-1], p2_q});
    end
  end

  // Magnitudes, signs and the common normalizing shift
  logic [MW-1:0] m_q [3];
  logic          neg_q [3];
  logic [MW-1:0] mag [3];
  logic [TW-1:0] tneg [3];
  logic [MW-1:0] m_or;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tneg[i] = -t_q[i];
      mag[i]  = t_q[i][TW-1] ? tneg[i][MW-1:0] : t_q[i][MW-1:0];
    end
    m_or = m_q[0] | m_q[1] | m_q[2];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd_i.abs_ld) begin
        m_q[i]   <= mag[i];
        neg_q[i] <= t_q[i][TW-1];
      end else if (cmd_i.norm_right) begin
        m_q[i] <= m_q[i] >> 1;
      end else if (cmd_i.norm_left) begin
        m_q[i] <= m_q[i] << 1;
      end
    end
  end

  // Sum of squares and bit-pair square root
  logic [2*NB-1:0] sqp_q;
  logic [SW-1:0]   s_q;
  logic [SW-1:0]   srem_q, sres_q, sbit_q;
  logic [SW-1:0]   ssum;
  logic [RTW-1:0]  root;

  assign ssum = sres_q + sbit_q;
  assign root = sres_q[RTW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_mul) sqp_q <= m_q[cmd_i.comp][NB-1:0] * m_q[cmd_i.comp][NB-1:0];
    if (cmd_i.sq_clr) s_q <= '0;
    else if (cmd_i.sq_acc) s_q <= s_q + SW'(sqp_q);
    if (cmd_i.sqrt_init) begin
      srem_q <= s_q;
      sres_q <= '0;
      sbit_q <= SW'(1) << (2 * NB);
    end else if (cmd_i.sqrt_step) begin
      if (srem_q >= ssum) begin
        srem_q <= srem_q - ssum;
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end

  // Restoring division, one quotient bit per cycle
  logic [ND-1:0]  ndiv;
  logic [RW-1:0]  drem_q;
  logic [QW-1:0]  dlo_q, dq_q;
  logic [CNW-1:0] dcnt_q;
  logic [RW-1:0]  trial;
  logic [QW-1:0]  qclip;
  logic [UW-1:0]  qext;
  logic signed [UW-1:0] tn_q [3];

  assign ndiv  = ND'({m_q[cmd_i.comp][NB-1:0], {FRAC{1'b0}}}) + ND'(root >> 1);
  assign trial = {drem_q[RW-2:0], dlo_q[QW-1]};
  assign qclip = (dq_q > QW'(ONE)) ? QW'(ONE) : dq_q;
  assign qext  = UW'(qclip);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      drem_q <= RW'(ndiv[ND-1:QW]);
      dlo_q  <= ndiv[QW-1:0];
      dq_q   <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      if (trial >= RW'(root)) begin
        drem_q <= trial - RW'(root);
        dq_q   <= {dq_q[QW-2:0], 1'b1};
      end else begin
        drem_q <= trial;
        dq_q   <= {dq_q[QW-2:0], 1'b0};
      end
      dlo_q  <= dlo_q << 1;
      dcnt_q <= dcnt_q + CNW'(1);
    end
    if (cmd_i.tn_zero) begin
      for (int i = 0; i < 3; i++) tn_q[i] <= '0;
    end else if (cmd_i.div_wr) begin
      tn_q[cmd_i.comp] <= neg_q[cmd_i.comp] ? -$signed(qext) : $signed(qext);
    end
  end

  // Cross products: normal x tangent, then binormal x normal
  logic signed [UW-1:0] nsel [3];
  logic signed [UW-1:0] xa [3];
  logic signed [UW-1:0] xb [3];
  logic signed [UW-1:0] b_q [3];
  logic signed [UW-1:0] tg_q [3];
  logic signed [PW-1:0] xp_q [6];

  always_comb begin
    case (cmd_i.corner)
      2'd0: begin
        nsel[0] = sn_x_q[0];
        nsel[1] = sn_y_q[0];
        nsel[2] = sn_z_q[0];
      end
      2'd1: begin
        nsel[0] = sn_x_q[1];
        nsel[1] = sn_y_q[1];
        nsel[2] = sn_z_q[1];
      end
      default: begin
        nsel[0] = cn_x_q;
        nsel[1] = cn_y_q;
        nsel[2] = cn_z_q;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      xa[i] = cmd_i.cross_sel ? b_q[i] : nsel[i];
      xb[i] = cmd_i.cross_sel ? nsel[i] : tn_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cross_ld) begin
      xp_q[0] <= xa[1] * xb[2];
      xp_q[1] <= xa[2] * xb[1];
      xp_q[2] <= xa[2] * xb[0];
      xp_q[3] <= xa[0] * xb[2];
      xp_q[4] <= xa[0] * xb[1];
      xp_q[5] <= xa[1] * xb[0];
    end
    for (int i = 0; i < 3; i++) begin
      if (cmd_i.b_ld) b_q[i] <= rsat_f(xp_q[2*i], xp_q[2*i+1]);
      if (cmd_i.tg_ld) tg_q[i] <= rsat_f(xp_q[2*i], xp_q[2*i+1]);
    end
  end

  // Output register: load a beat, drop valid once taken
  logic                 out_valid_q;
  logic [1:0]           corner_q;
  logic                 face_done_q;
  logic signed [UW-1:0] otan_q [3];
  logic signed [UW-1:0] obin_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      corner_q    <= cmd_i.corner;
      face_done_q <= (cmd_i.corner == CORNER_LAST);
      for (int i = 0; i < 3; i++) begin
        otan_q[i] <= tg_q[i];
        obin_q[i] <= b_q[i];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign corner_o    = corner_q;
  assign face_done_o = face_done_q;
  assign tan_x_o     = otan_q[0];
  assign tan_y_o     = otan_q[1];
  assign tan_z_o     = otan_q[2];
  assign bin_x_o     = obin_q[0];
  assign bin_y_o     = obin_q[1];
  assign bin_z_o     = obin_q[2];

  // Status back to the sequencer
  always_comb begin
    sts_o            = '0;
    sts_o.mag_zero   = (m_or == '0);
    sts_o.norm_right = |m_or[MW-1:NB];
    sts_o.norm_left  = (m_or != '0) && !(|m_or[MW-1:NB-1]);
    sts_o.sqrt_last  = sbit_q[0];
    sts_o.div_last   = (dcnt_q == CNW'(QW - 1));
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

### sv/triangle_tangent_frame_core.sv
// Top level of the per-triangle tangent frame core: sequencer plus datapath.
//
//  channel  dir  beat                                   handshake
//  in_if    in   one vertex: pos, tex u/v, normal       valid/ready
//  out_if   out  one corner frame: tangent, binormal    valid/ready
//
// Corners 0 and 1 of a face are only stored when taken.
// Corner 2 starts the face: the tangent is normalized by a shift of N bits (up to 29), one
// bit per cycle; the square root and three 15-bit divisions follow. A zero tangent skips
// to the cross products. The three frame beats, one per corner, then follow in turn.
// Input ready is high only while no face is in work.
// Reset clears the sequencer, the corner count and the output valid; stored vertices hold.
// A stalled output beat holds the sequencer in its emit step.
module triangle_tangent_frame_core #(
  parameter int COORD_WIDTH = ttf_pkg::COORD_WIDTH_DEF,
  parameter int UNIT_WIDTH  = ttf_pkg::UNIT_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ttf_in_if.sink     in_if,
  ttf_out_if.source  out_if
);
  import ttf_pkg::*;

  ttf_cmd_t cmd;
  ttf_sts_t sts;

  ttf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ttf_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .UNIT_WIDTH  (UNIT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .pos_x_i     (in_if.pos_x),
    .pos_y_i     (in_if.pos_y),
    .pos_z_i     (in_if.pos_z),
    .tex_v_i     (in_if.tex_v),
    .norm_x_i    (in_if.norm_x),
    .norm_y_i    (in_if.norm_y),
    .norm_z_i    (in_if.norm_z),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .corner_o    (out_if.corner),
    .tan_x_o     (out_if.tan_x),
    .tan_y_o     (out_if.tan_y),
    .tan_z_o     (out_if.tan_z),
    .bin_x_o     (out_if.bin_x),
    .bin_y_o     (out_if.bin_y),
    .bin_z_o     (out_if.bin_z),
    .face_done_o (out_if.face_done)
  );

  // A new frame never overwrites a beat still waiting at the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |-> sts.out_free)
    else $error("frame loaded over a pending output beat");

  // The last corner of a face is the one flagged as face end
  a_face_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.face_done == (out_if.corner == CORNER_LAST)))
    else $error("face_done does not match corner");

  // No vertex is taken while a face is being worked on
  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.tprod || cmd.sqrt_step || cmd.div_step || cmd.cross_ld) |-> !in_if.ready)
    else $error("input ready while face in work");

  // Component index stays within the three axes
  a_comp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.tprod || cmd.tdiff || cmd.sq_mul || cmd.div_wr) |-> (cmd.comp != 2'd3))
    else $error("component index out of range");

endmodule
